[rtl/i2c_master_single_byte_transfer_assert.svh]
// Assertion macros for the single-byte I2C master checker.
// Needs nothing else; included by the checker file.
`ifndef I2C_MASTER_SINGLE_BYTE_TRANSFER_ASSERT_SVH
`define I2C_MASTER_SINGLE_BYTE_TRANSFER_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2cm_pkg.sv]
// Shared types and constants for the single-byte I2C master.
// No dependencies.
`default_nettype none

package i2cm_pkg;

    localparam int unsigned ADDR_W = 7;
    localparam int unsigned HOLD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'h38;
    localparam logic [HOLD_W-1:0] LOW_HOLD_RST = 16'd5;
    localparam logic [HOLD_W-1:0] HIGH_HOLD_RST = 16'd4;
    localparam logic [BIT_W-1:0]  ACK_SLOT = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR  = 2'd0,
        CFG_LOW_HOLD  = 2'd1,
        CFG_HIGH_HOLD = 2'd2
    } t_cfg_idx;

    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_START_WAIT = 10'b00_0000_0010,
        PH_START_HOLD = 10'b00_0000_0100,
        PH_ADDR_LOW   = 10'b00_0000_1000,
        PH_ADDR_HIGH  = 10'b00_0001_0000,
        PH_DATA_LOW   = 10'b00_0010_0000,
        PH_DATA_HIGH  = 10'b00_0100_0000,
        PH_STOP_LOW   = 10'b00_1000_0000,
        PH_STOP_HIGH  = 10'b01_0000_0000,
        PH_STOP_FREE  = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic              start_request;
        logic              mode;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
        logic              scl_in;
    } t_req;

    typedef struct packed {
        logic              scl_drive_low;
        logic              sda_drive_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              address_acked;
        logic              data_acked;
    } t_res;

endpackage

`default_nettype wire

[rtl/i2cm_stream_if.sv]
// Valid/ready channel carrying one payload of type T.
// Used with i2cm_pkg::t_req and i2cm_pkg::t_res.
`default_nettype none

interface i2cm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/i2c_master_single_byte_transfer.sv]
// Single-byte I2C master, one bus tick per request.
// An accepted request is held in the request register, then its result in the result register.
// Throughput: one request per cycle; the state update is a single pass over the phase machine.
// Backpressure on the result channel stalls both stages; requests flow again once it drains.
// Reset (i_rst_n low, synchronous): both stages empty, phase idle, registers at defaults.
// Depends on i2cm_pkg and i2cm_stream_if.
`default_nettype none

module i2c_master_single_byte_transfer (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    i2cm_stream_if.sink                           i_req,
    i2cm_stream_if.source                         o_res,
    input  wire                                   i_cfg_we,
    input  wire [i2cm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [i2cm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // ---- configuration registers -------------------------------------
    logic [i2cm_pkg::ADDR_W-1:0] r_dev_addr;
    logic [i2cm_pkg::HOLD_W-1:0] r_low_hold;
    logic [i2cm_pkg::HOLD_W-1:0] r_high_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= i2cm_pkg::DEV_ADDR_RST;
            r_low_hold  <= i2cm_pkg::LOW_HOLD_RST;
            r_high_hold <= i2cm_pkg::HIGH_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cm_pkg::CFG_DEV_ADDR:  r_dev_addr  <= i_cfg_data[i2cm_pkg::ADDR_W-1:0];
                i2cm_pkg::CFG_LOW_HOLD:  r_low_hold  <= i_cfg_data;
                i2cm_pkg::CFG_HIGH_HOLD: r_high_hold <= i_cfg_data;
                default: ;  // spare index: ignored
            endcase
        end
    end

    // ---- pipeline control ----------------------------------------------
    // Stage 1 holds the accepted request; stage 2 is the result register.
    // The step runs when stage 1 is full and the result register can take it.
    logic           r_in_valid;
    i2cm_pkg::t_req r_in;
    logic           r_out_valid;
    i2cm_pkg::t_res r_out;
    logic           step;

    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || step;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
    end

    // ---- transaction state ---------------------------------------------
    i2cm_pkg::t_phase            r_phase,   n_phase;
    logic [i2cm_pkg::BIT_W-1:0]  r_bit,     n_bit;
    logic [i2cm_pkg::HOLD_W-1:0] r_hold,    n_hold;
    logic [i2cm_pkg::BYTE_W-1:0] r_shift,   n_shift;
    logic                        r_dir,     n_dir;
    logic [i2cm_pkg::BYTE_W-1:0] r_rx,      n_rx;
    logic [1:0]                  r_ack,     n_ack;

    // Hold limits: a zero count behaves as one tick, so compare against limit-1.
    logic [i2cm_pkg::HOLD_W-1:0] low_last;
    logic [i2cm_pkg::HOLD_W-1:0] high_last;
    logic                        low_done;
    logic                        high_done;

    assign low_last  = (r_low_hold  == '0) ? '0 : r_low_hold  - 1'b1;
    assign high_last = (r_high_hold == '0) ? '0 : r_high_hold - 1'b1;
    assign low_done  = (r_hold >= low_last);
    assign high_done = (r_hold >= high_last);

    // Bit currently on SDA: address byte in the address slots, else the data byte.
    // Ack slot releases SDA; a read releases it for the slave's data bits too.
    logic [i2cm_pkg::BYTE_W-1:0] addr_byte;
    logic [i2cm_pkg::BYTE_W-1:0] tx_byte;
    logic [2:0]                  bit_sel;
    logic                        is_addr;
    logic                        data_sda_low;

    assign addr_byte = {r_dev_addr, r_dir};
    assign is_addr   = (r_phase == i2cm_pkg::PH_ADDR_LOW) || (r_phase == i2cm_pkg::PH_ADDR_HIGH);
    assign tx_byte   = is_addr ? addr_byte : r_shift;
    assign bit_sel   = 3'd7 - r_bit[2:0];

    always_comb begin
        if (r_bit >= i2cm_pkg::ACK_SLOT) begin
            data_sda_low = 1'b0;
        end else if (!is_addr && r_dir) begin
            data_sda_low = 1'b0;
        end else begin
            data_sda_low = ~tx_byte[bit_sel];
        end
    end

    logic scl_low;
    logic sda_low;
    logic done;

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_hold  = r_hold;
        n_shift = r_shift;
        n_dir   = r_dir;
        n_rx    = r_rx;
        n_ack   = r_ack;
        scl_low = 1'b0;
        sda_low = 1'b0;
        done    = 1'b0;

        unique case (r_phase)
            i2cm_pkg::PH_IDLE: begin
                if (r_in.start_request) begin
                    n_dir   = r_in.mode;
                    n_shift = r_in.write_data;
                    n_ack   = 2'b00;
                    n_bit   = '0;
                    n_hold  = '0;
                    if (r_in.mode) begin
                        n_rx = '0;
                    end
                    n_phase = i2cm_pkg::PH_START_WAIT;
                end
            end
            i2cm_pkg::PH_START_WAIT: begin
                // SCL must read high for the setup time before the start
                if (r_in.scl_in) begin
                    n_hold = low_done ? '0 : r_hold + 1'b1;
                    if (low_done) begin
                        n_phase = i2cm_pkg::PH_START_HOLD;
                    end
                end
            end
            i2cm_pkg::PH_START_HOLD: begin
                sda_low = 1'b1;
                n_hold  = high_done ? '0 : r_hold + 1'b1;
                if (high_done) begin
                    n_bit   = '0;
                    n_phase = i2cm_pkg::PH_ADDR_LOW;
                end
            end
            i2cm_pkg::PH_ADDR_LOW, i2cm_pkg::PH_DATA_LOW: begin
                scl_low = 1'b1;
                sda_low = data_sda_low;
                n_hold  = low_done ? '0 : r_hold + 1'b1;
                if (low_done) begin
                    n_phase = (r_phase == i2cm_pkg::PH_ADDR_LOW) ?
                              i2cm_pkg::PH_ADDR_HIGH : i2cm_pkg::PH_DATA_HIGH;
                end
            end
            i2cm_pkg::PH_ADDR_HIGH, i2cm_pkg::PH_DATA_HIGH: begin
                sda_low = data_sda_low;
                // stretched clock: hold count pauses while SCL reads low
                if (r_in.scl_in) begin
                    n_hold = high_done ? '0 : r_hold + 1'b1;
                    if (high_done) begin
                        if (r_bit >= i2cm_pkg::ACK_SLOT) begin
                            if (is_addr) begin
                                if (!r_in.sda_in) begin
                                    n_ack[0] = 1'b1;
                                end
                                n_phase = i2cm_pkg::PH_DATA_LOW;
                            end else begin
                                if (!r_dir && !r_in.sda_in) begin
                                    n_ack[1] = 1'b1;
                                end
                                n_phase = i2cm_pkg::PH_STOP_LOW;
                            end
                            n_bit = '0;
                        end else begin
                            if (!is_addr && r_dir) begin
                                n_rx = {r_rx[i2cm_pkg::BYTE_W-2:0], r_in.sda_in};
                            end
                            n_bit   = r_bit + 1'b1;
                            n_phase = is_addr ? i2cm_pkg::PH_ADDR_LOW : i2cm_pkg::PH_DATA_LOW;
                        end
                    end
                end
            end
            i2cm_pkg::PH_STOP_LOW: begin
                scl_low = 1'b1;
                sda_low = 1'b1;
                n_hold  = low_done ? '0 : r_hold + 1'b1;
                if (low_done) begin
                    n_phase = i2cm_pkg::PH_STOP_HIGH;
                end
            end
            i2cm_pkg::PH_STOP_HIGH: begin
                sda_low = 1'b1;
                if (r_in.scl_in) begin
                    n_hold = high_done ? '0 : r_hold + 1'b1;
                    if (high_done) begin
                        n_phase = i2cm_pkg::PH_STOP_FREE;
                    end
                end
            end
            i2cm_pkg::PH_STOP_FREE: begin
                // bus-free time after the stop condition
                n_hold = low_done ? '0 : r_hold + 1'b1;
                if (low_done) begin
                    done    = 1'b1;
                    n_phase = i2cm_pkg::PH_IDLE;
                end
            end
            default: begin
                // corrupted phase code: release lines and recover
                n_phase = i2cm_pkg::PH_IDLE;
                n_hold  = '0;
                n_bit   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cm_pkg::PH_IDLE;
            r_bit   <= '0;
            r_hold  <= '0;
            r_shift <= '0;
            r_dir   <= 1'b0;
            r_rx    <= '0;
            r_ack   <= 2'b00;
        end else if (step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_hold  <= n_hold;
            r_shift <= n_shift;
            r_dir   <= n_dir;
            r_rx    <= n_rx;
            r_ack   <= n_ack;
        end
    end

    // Result register: drives and busy belong to the phase at the start of the tick,
    // ack flags and received byte reflect the state after it.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.scl_drive_low <= scl_low;
            r_out.sda_drive_low <= sda_low;
            r_out.busy_res      <= (r_phase != i2cm_pkg::PH_IDLE);
            r_out.done_res      <= done;
            r_out.read_data     <= n_rx;
            r_out.address_acked <= n_ack[0];
            r_out.data_acked    <= n_ack[1];
        end
    end

endmodule

`default_nettype wire

[rtl/i2cm_checker.sv]
// Port-level checker for the single-byte I2C master, bound to the top level.
// Depends on i2cm_pkg and the assertion macro header.
`default_nettype none

`include "i2c_master_single_byte_transfer_assert.svh"

module i2cm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input wire i2cm_pkg::t_res i_out_payload
);

    // a stalled result keeps its contents
    `I2CM_ASSERT_NXT(a_res_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_payload),
        "stalled result changed")

    // completion is only reported from inside a transaction
    `I2CM_ASSERT_IMP(a_done_busy, i_clk, i_rst_n,
        i_out_valid && i_out_payload.done_res,
        i_out_payload.busy_res,
        "done outside transaction")

    // completion tick lies in the bus-free time: both lines released
    `I2CM_ASSERT_IMP(a_done_free, i_clk, i_rst_n,
        i_out_valid && i_out_payload.done_res,
        !i_out_payload.scl_drive_low && !i_out_payload.sda_drive_low,
        "line driven at done")

    // the master never drives the bus while idle
    `I2CM_ASSERT_IMP(a_idle_release, i_clk, i_rst_n,
        i_out_valid && !i_out_payload.busy_res,
        !i_out_payload.scl_drive_low && !i_out_payload.sda_drive_low,
        "line driven while idle")

endmodule

bind i2c_master_single_byte_transfer i2cm_checker u_i2cm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_payload (o_res.payload)
);

`default_nettype wire
